FILE: sv/bsk_pkg.sv
// Shared types and constants for the bounded key stack.
`default_nettype none

package bsk_pkg;

   // Widths of the word fields as seen on the channels
   localparam int FIELD_KEY_BITS  = 64;
   localparam int FILL_BITS       = 4;

   typedef enum logic [1:0] {
      ACT_PUSH   = 2'd0,
      ACT_POP    = 2'd1,
      ACT_REMOVE = 2'd2,
      ACT_SEARCH = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_FULL    = 2'd1,
      ST_EMPTY   = 2'd2,
      ST_MISSING = 2'd3
   } status_type;

   // Per-cycle control broadcast to every cell
   typedef struct packed {
      logic push_ok;
      logic remove_hit;
   } cell_ctrl_type;

endpackage

`default_nettype wire

FILE: sv/bsk_if.sv
// Request and response channel interfaces for the bounded key stack.
`default_nettype none

interface bsk_req_if;
   import bsk_pkg::*;

   logic                      valid;
   logic                      ready;
   action_type                action;
   logic [FIELD_KEY_BITS-1:0] key;

   modport source (output valid, output action, output key, input ready);
   modport sink   (input valid, input action, input key, output ready);
endinterface

interface bsk_rsp_if;
   import bsk_pkg::*;

   logic                      valid;
   logic                      ready;
   status_type                status;
   logic [FIELD_KEY_BITS-1:0] out_key;
   logic                      found;
   logic [FILL_BITS-1:0]      fill_count;
   logic [FIELD_KEY_BITS-1:0] top_key;
   logic                      is_empty;

   modport source (output valid, output status, output out_key, output found,
                   output fill_count, output top_key, output is_empty, input ready);
   modport sink   (input valid, input status, input out_key, input found,
                   input fill_count, input top_key, input is_empty, output ready);
endinterface

`default_nettype wire

FILE: sv/bounded_stack_with_key_removal.sv
// Top level of the bounded LIFO key stack with push, pop, remove and search.
`default_nettype none

// A LIFO of DEPTH keys, KEY_BITS wide, built as a row of cells, one per slot.
// Each request word carries one action (push, pop, remove topmost match,
// search) and yields exactly one response word in the cycle after it is taken.
// Every action is resolved combinationally: all cells compare their key with
// the request key at once, a hit flag ripples from the top cell to the bottom
// one to find the topmost match, and the cells above the removed slot shift
// down in the same edge. The ripple through DEPTH cells sets the clock period.
// A new request is taken in every cycle in which the response register is
// empty or being drained, so one word per cycle is sustained. Slot contents
// are not cleared by reset; only slots below the fill count are ever read.
// Keys are cut to KEY_BITS; fill_count reports the low four count bits.
module bounded_stack_with_key_removal #(
   parameter int DEPTH    = 8,
   parameter int KEY_BITS = 64
) (
   input wire         clock,
   input wire         reset,
   bsk_req_if.sink    req_bus,
   bsk_rsp_if.source  rsp_bus
);
   import bsk_pkg::*;

   localparam int CNT_BITS = $clog2(DEPTH + 1);

   // ------------------------------------------------------------------
   // State
   // ------------------------------------------------------------------
   logic [CNT_BITS-1:0]       count_ff, count_in;
   logic [KEY_BITS-1:0]       top_ff, top_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   status_type                status_ff, status_in;
   logic [FIELD_KEY_BITS-1:0] out_key_ff, out_key_in;
   logic                      found_ff, found_in;
   logic [FILL_BITS-1:0]      fill_ff, fill_in;
   logic [FIELD_KEY_BITS-1:0] top_key_ff, top_key_in;
   logic                      empty_ff, empty_in;

   logic                      accept;
   logic [KEY_BITS-1:0]       key_m;
   logic                      full;
   logic                      empty;
   logic                      hit;
   cell_ctrl_type             ctrl;

   logic [KEY_BITS-1:0]       entry_q    [DEPTH];
   logic [KEY_BITS-1:0]       entry_next [DEPTH];
   logic [DEPTH:0]            above;
   logic [KEY_BITS-1:0]       top_sel;
   logic [CNT_BITS+FILL_BITS-1:0] fill_wide;

   // Take a word whenever the response slot is free or draining
   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign accept        = req_bus.valid && req_bus.ready;

   assign key_m = req_bus.key[KEY_BITS-1:0];
   assign full  = count_ff == CNT_BITS'(DEPTH);
   assign empty = count_ff == '0;

   // Hit flag enters above the top cell and ripples down to slot 0
   assign above[DEPTH] = 1'b0;
   assign hit          = above[0];

   // Broadcast control, qualified by the handshake
   always_comb begin
      ctrl.push_ok    = accept && (req_bus.action == ACT_PUSH) && !full;
      ctrl.remove_hit = accept && (req_bus.action == ACT_REMOVE) && hit;
   end

   // ------------------------------------------------------------------
   // Cell row
   // ------------------------------------------------------------------
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [KEY_BITS-1:0] up_key;

      if (i == DEPTH - 1) begin : g_top
         assign up_key = entry_q[i];
      end else begin : g_mid
         assign up_key = entry_q[i + 1];
      end

      bsk_cell #(
         .KEY_BITS (KEY_BITS),
         .CNT_BITS (CNT_BITS),
         .INDEX    (i)
      ) u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .count      (count_ff),
         .key        (key_m),
         .up_key     (up_key),
         .above_hit  (above[i + 1]),
         .chain_hit  (above[i]),
         .entry_q    (entry_q[i]),
         .entry_next (entry_next[i])
      );
   end

   // ------------------------------------------------------------------
   // Action decode and next count
   // ------------------------------------------------------------------
   always_comb begin
      count_in  = count_ff;
      status_in = ST_OK;
      out_key_in = '0;
      found_in  = 1'b0;
      case (req_bus.action)
         ACT_PUSH: begin
            if (full) begin
               status_in = ST_FULL;
            end else begin
               count_in = count_ff + CNT_BITS'(1);
            end
         end
         ACT_POP: begin
            if (empty) begin
               status_in = ST_EMPTY;
            end else begin
               count_in = count_ff - CNT_BITS'(1);
               out_key_in[KEY_BITS-1:0] = top_ff;
            end
         end
         ACT_REMOVE: begin
            if (empty) begin
               status_in = ST_EMPTY;
            end else if (!hit) begin
               status_in = ST_MISSING;
            end else begin
               found_in = 1'b1;
               count_in = count_ff - CNT_BITS'(1);
            end
         end
         ACT_SEARCH: begin
            if (empty) begin
               status_in = ST_EMPTY;
            end else if (!hit) begin
               status_in = ST_MISSING;
            end else begin
               found_in = 1'b1;
            end
         end
         default: begin
            status_in = ST_OK;
         end
      endcase
   end

   // Pick the new top slot from the cells' next contents (zero when empty)
   always_comb begin
      top_sel = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if (count_in == CNT_BITS'(i + 1)) begin
            top_sel = entry_next[i];
         end
      end
   end

   always_comb begin
      top_in = top_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      fill_wide = '0;
      fill_wide[CNT_BITS-1:0] = count_in;
      fill_in = fill_wide[FILL_BITS-1:0];
      top_key_in = '0;
      top_key_in[KEY_BITS-1:0] = top_sel;
      empty_in = count_in == '0;
      if (accept) begin
         top_in       = top_sel;
         rsp_valid_in = 1'b1;
      end
   end

   // ------------------------------------------------------------------
   // Registers
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         top_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         top_ff       <= top_in;
         if (accept) begin
            count_ff <= count_in;
         end
      end
   end

   // Hold the response word until taken; load only on a new request
   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff  <= status_in;
         out_key_ff <= out_key_in;
         found_ff   <= found_in;
         fill_ff    <= fill_in;
         top_key_ff <= top_key_in;
         empty_ff   <= empty_in;
      end
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.status     = status_ff;
   assign rsp_bus.out_key    = out_key_ff;
   assign rsp_bus.found      = found_ff;
   assign rsp_bus.fill_count = fill_ff;
   assign rsp_bus.top_key    = top_key_ff;
   assign rsp_bus.is_empty   = empty_ff;

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_BITS'(DEPTH))
      else $error("fill count beyond depth");

   a_empty_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (empty_ff == (count_ff == '0)))
      else $error("empty flag disagrees with fill count");

   a_full_push: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_bus.action == ACT_PUSH) && full) |=> $stable(count_ff))
      else $error("refused push changed the fill count");

   a_remove_dec: assert property (@(posedge clock) disable iff (reset)
      ctrl.remove_hit |=> (count_ff == $past(count_ff) - CNT_BITS'(1)))
      else $error("remove hit did not drop one entry");
`endif

endmodule

`default_nettype wire

FILE: sv/bsk_cell.sv
// One stack slot: holds a key, compares it, and shifts down on removal.
`default_nettype none

module bsk_cell #(
   parameter int KEY_BITS = 64,
   parameter int CNT_BITS = 4,
   parameter int INDEX    = 0
) (
   input  wire                        clock,
   input  wire bsk_pkg::cell_ctrl_type ctrl,
   input  wire  [CNT_BITS-1:0]        count,
   input  wire  [KEY_BITS-1:0]        key,
   input  wire  [KEY_BITS-1:0]        up_key,
   input  wire                        above_hit,
   output logic                       chain_hit,
   output logic [KEY_BITS-1:0]        entry_q,
   output logic [KEY_BITS-1:0]        entry_next
);
   import bsk_pkg::*;

   logic [KEY_BITS-1:0] entry_ff;
   logic [KEY_BITS-1:0] entry_in;
   logic                in_range;
   logic                match;

   assign in_range  = count > CNT_BITS'(INDEX);
   assign match     = in_range && (entry_ff == key);
   assign chain_hit = above_hit | match;

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.push_ok && (count == CNT_BITS'(INDEX))) begin
         entry_in = key;
      end else if (ctrl.remove_hit && !above_hit) begin
         // at or above the removed slot: take the neighbor's key
         entry_in = up_key;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry_q    = entry_ff;
   assign entry_next = entry_in;

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
// Self-checking bench for the bounded key stack: directed table, then random words.
module tb_top;
   import bsk_pkg::*;

   // Geometry of the instance under test; the model below keeps its own copy.
   localparam int STACK_DEPTH = 8;
   localparam int STALL_LIMIT = 5000;   // cycles with no word moving on either channel
   localparam int LONG_HOLD   = 300;    // receiver hold-off that fills the block
   localparam int PHASE_WORDS = 150;    // random words per idling phase
   localparam int TAIL_CYCLES = 8;      // settle time after the last response

   localparam logic [63:0] K_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] K_MSB  = 64'h8000_0000_0000_0000;
   localparam logic [63:0] K_MIX  = 64'h0123_4567_89AB_CDEF;
   localparam logic [63:0] K_ALT5 = 64'h5555_5555_5555_5555;
   localparam logic [63:0] K_ALTA = 64'hAAAA_AAAA_AAAA_AAAA;

   // One response word, in port order.
   typedef struct packed {
      status_type  status;
      logic [63:0] out_key;
      logic        found;
      logic [3:0]  fill_count;
      logic [63:0] top_key;
      logic        is_empty;
   } reply_type;

   // One request word plus an optional hand-written expectation.
   typedef struct packed {
      action_type  act;
      logic [63:0] key;
      logic        typed;
      reply_type   reply;
   } stim_row_type;

   localparam reply_type NO_TYPED = '0;

   // Directed table. Rows with typed set carry a response read straight off the
   // spec (after reset, empty/full/missing status, extremes); the rest use the model.
   localparam stim_row_type DIRECTED_ROWS [24] = '{
      '{ACT_POP,    64'd0, 1'b1, '{ST_EMPTY,   64'd0, 1'b0, 4'd0, 64'd0,  1'b1}},
      '{ACT_SEARCH, 64'd5, 1'b1, '{ST_EMPTY,   64'd0, 1'b0, 4'd0, 64'd0,  1'b1}},
      '{ACT_REMOVE, 64'd5, 1'b1, '{ST_EMPTY,   64'd0, 1'b0, 4'd0, 64'd0,  1'b1}},
      '{ACT_PUSH,   64'd0, 1'b1, '{ST_OK,      64'd0, 1'b0, 4'd1, 64'd0,  1'b0}},
      '{ACT_PUSH,   K_ONES, 1'b1, '{ST_OK,     64'd0, 1'b0, 4'd2, K_ONES, 1'b0}},
      '{ACT_PUSH,   K_MSB,  1'b1, '{ST_OK,     64'd0, 1'b0, 4'd3, K_MSB,  1'b0}},
      '{ACT_PUSH,   64'd1,  1'b0, NO_TYPED},
      '{ACT_PUSH,   K_ALT5, 1'b0, NO_TYPED},
      '{ACT_PUSH,   K_ALTA, 1'b0, NO_TYPED},
      '{ACT_PUSH,   K_ONES, 1'b0, NO_TYPED},
      '{ACT_PUSH,   K_MIX,  1'b1, '{ST_OK,     64'd0, 1'b0, 4'd8, K_MIX,  1'b0}},
      '{ACT_PUSH,   64'd7,  1'b1, '{ST_FULL,   64'd0, 1'b0, 4'd8, K_MIX,  1'b0}},
      '{ACT_SEARCH, K_ONES, 1'b0, NO_TYPED},
      '{ACT_SEARCH, 64'd2,  1'b1, '{ST_MISSING, 64'd0, 1'b0, 4'd8, K_MIX, 1'b0}},
      '{ACT_REMOVE, 64'd2,  1'b1, '{ST_MISSING, 64'd0, 1'b0, 4'd8, K_MIX, 1'b0}},
      '{ACT_REMOVE, K_ONES, 1'b0, NO_TYPED},
      '{ACT_REMOVE, 64'd0,  1'b0, NO_TYPED},
      '{ACT_REMOVE, K_MIX,  1'b0, NO_TYPED},
      '{ACT_POP,    K_ONES, 1'b0, NO_TYPED},
      '{ACT_POP,    64'd0,  1'b0, NO_TYPED},
      '{ACT_POP,    64'd0,  1'b0, NO_TYPED},
      '{ACT_POP,    64'd0,  1'b0, NO_TYPED},
      '{ACT_POP,    64'd0,  1'b0, NO_TYPED},
      '{ACT_POP,    K_ONES, 1'b1, '{ST_EMPTY,  64'd0, 1'b0, 4'd0, 64'd0,  1'b1}}
   };

   logic clock;
   logic reset;

   bsk_req_if req_bus ();
   bsk_rsp_if rsp_bus ();

   bounded_stack_with_key_removal #(
      .DEPTH    (STACK_DEPTH),
      .KEY_BITS (64)
   ) uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // Model state: slot 0 is the bottom of the stack.
   logic [63:0] held_keys [STACK_DEPTH];
   int          held_count = 0;

   stim_row_type offered_words [$];    // words put on the request bus, not yet taken
   reply_type    pending_replies [$];  // responses owed by the block, oldest first

   int          mismatches   = 0;
   int          idle_pct     = 0;     // sender: chance in 100 of a gap before a word
   int          stall_pct    = 0;     // receiver: chance in 100 of dropping ready
   int          hold_ask     = 0;     // long hold-off requested of the receiver
   int          hold_left    = 0;
   int          quiet_cycles = 0;
   logic [63:0] key_pool [6];

   // Apply one action to the model stack and return the response it owes.
   function automatic reply_type stack_step_reply(action_type act, logic [63:0] key);
      reply_type r;
      int        slot;
      r    = '0;
      slot = -1;
      r.status = ST_OK;
      case (act)
         ACT_PUSH: begin
            if (held_count >= STACK_DEPTH) begin
               r.status = ST_FULL;
            end else begin
               held_keys[held_count] = key;
               held_count++;
            end
         end
         ACT_POP: begin
            if (held_count == 0) begin
               r.status = ST_EMPTY;
            end else begin
               held_count--;
               r.out_key = held_keys[held_count];
            end
         end
         ACT_REMOVE: begin
            if (held_count == 0) begin
               r.status = ST_EMPTY;
            end else begin
               // take the topmost match, then close the gap from above
               for (int i = held_count - 1; i >= 0; i--)
                  if (slot < 0 && held_keys[i] == key) slot = i;
               if (slot < 0) begin
                  r.status = ST_MISSING;
               end else begin
                  r.found = 1'b1;
                  for (int i = slot; i < held_count - 1; i++) held_keys[i] = held_keys[i + 1];
                  held_count--;
               end
            end
         end
         default: begin
            if (held_count == 0) begin
               r.status = ST_EMPTY;
            end else begin
               for (int i = 0; i < held_count; i++)
                  if (held_keys[i] == key) r.found = 1'b1;
               if (!r.found) r.status = ST_MISSING;
            end
         end
      endcase
      r.fill_count = 4'(held_count);
      r.top_key    = (held_count == 0) ? 64'd0 : held_keys[held_count - 1];
      r.is_empty   = (held_count == 0);
      return r;
   endfunction

   // Random word. Keys come mostly from a small pool so that search and remove
   // hit often; the push share swings every 16 words so the stack runs both
   // into full and into empty.
   function automatic stim_row_type random_word(int n);
      stim_row_type w;
      int           push_pct;
      int           roll;
      w        = '0;
      push_pct = ((n / 16) % 2 != 0) ? 65 : 25;
      roll     = $urandom_range(99);
      if (roll < push_pct) begin
         w.act = ACT_PUSH;
      end else begin
         case ($urandom_range(2))
            0:       w.act = ACT_POP;
            1:       w.act = ACT_REMOVE;
            default: w.act = ACT_SEARCH;
         endcase
      end
      if ($urandom_range(99) < 70) w.key = key_pool[$urandom_range(5)];
      else                         w.key = {$urandom, $urandom};
      return w;
   endfunction

   // Offer one word after a random gap and hold it until the block takes it.
   task automatic send_word(stim_row_type w);
      while ($urandom_range(99) < idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      offered_words.push_back(w);
      req_bus.valid  <= 1'b1;
      req_bus.action <= w.act;
      req_bus.key    <= w.key;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   // Drop valid and wait until every owed response has come back.
   task automatic drain_replies();
      req_bus.valid <= 1'b0;
      while (pending_replies.size() != 0 || offered_words.size() != 0) @(posedge clock);
   endtask

   // Free-running clock, period 2.
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Receiver: random stalls at the current rate, or a long hold-off on request.
   always @(posedge clock) begin
      if (hold_ask > 0) begin
         hold_left = hold_ask;
         hold_ask  = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // Scoreboard: predict on every taken request word, check every taken
   // response word against the oldest prediction. Bus values are read before
   // this edge's updates land, so sampling does not race the drivers.
   always @(posedge clock) begin
      stim_row_type word;
      reply_type    want;
      reply_type    got;
      if (!reset) begin
         if (req_bus.valid && req_bus.ready && offered_words.size() != 0) begin
            word = offered_words.pop_front();
            want = stack_step_reply(req_bus.action, req_bus.key);
            if (word.typed) want = word.reply;
            pending_replies.push_back(want);
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            got = '{rsp_bus.status, rsp_bus.out_key, rsp_bus.found, rsp_bus.fill_count,
                    rsp_bus.top_key, rsp_bus.is_empty};
            if (pending_replies.size() == 0) begin
               mismatches++;
               $display("%0t unexpected response: expected none actual %h", $time, got);
            end else begin
               want = pending_replies.pop_front();
               if (got.status !== want.status) begin
                  mismatches++;
                  $display("%0t status: expected %0d actual %0d",
                           $time, want.status, got.status);
               end
               if (got.out_key !== want.out_key) begin
                  mismatches++;
                  $display("%0t out_key: expected %h actual %h",
                           $time, want.out_key, got.out_key);
               end
               if (got.found !== want.found) begin
                  mismatches++;
                  $display("%0t found: expected %b actual %b", $time, want.found, got.found);
               end
               if (got.fill_count !== want.fill_count) begin
                  mismatches++;
                  $display("%0t fill_count: expected %0d actual %0d",
                           $time, want.fill_count, got.fill_count);
               end
               if (got.top_key !== want.top_key) begin
                  mismatches++;
                  $display("%0t top_key: expected %h actual %h",
                           $time, want.top_key, got.top_key);
               end
               if (got.is_empty !== want.is_empty) begin
                  mismatches++;
                  $display("%0t is_empty: expected %b actual %b",
                           $time, want.is_empty, got.is_empty);
               end
            end
         end
      end
   end

   // Watchdog: end the run if no word moves on either channel for too long.
   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // Main sequence: reset, directed table, then four idling phases of random words.
   initial begin
      reset          = 1'b1;
      req_bus.valid  = 1'b0;
      req_bus.action = ACT_PUSH;
      req_bus.key    = '0;
      rsp_bus.ready  = 1'b0;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Walk the directed table with no gaps on either side.
      foreach (DIRECTED_ROWS[r]) send_word(DIRECTED_ROWS[r]);
      drain_replies();

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0:       begin idle_pct = 0;  stall_pct = 0;  end
            1:       begin idle_pct = 79; stall_pct = 0;  end
            2:       begin idle_pct = 0;  stall_pct = 79; end
            default: begin idle_pct = 8;  stall_pct = 8;  end
         endcase
         // refresh the key pool; keep both all-zero and all-one keys in it
         key_pool[0] = '0;
         key_pool[1] = '1;
         for (int k = 2; k < 6; k++) key_pool[k] = {$urandom, $urandom};

         for (int n = 0; n < PHASE_WORDS; n++) begin
            // hold the receiver off while words keep coming, so the block backs up
            if (phase == 0 && n == 60) hold_ask = LONG_HOLD;
            // pause the sender until every owed response is back
            if (phase == 1 && n == 75) drain_replies();
            send_word(random_word(n));
         end
         drain_replies();
      end

      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
